// ===== src/dlts_pkg.sv =====
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared widths, codes and types of the delta-list task scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int OP_W      = 3;
  localparam int ID_W      = 8;
  localparam int DELAY_W   = 16;
  localparam int PER_W     = 16;
  localparam int DELTA_W   = 32;
  localparam int SCALE_W   = 8;
  localparam int TC_W      = 5;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 3'd0,
    OP_TICK     = 3'd1,
    OP_DISPATCH = 3'd2,
    OP_CHECK    = 3'd3,
    OP_DELETE   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_SHIFT,
    ST_TICK,
    ST_DISP,
    ST_SRCH,
    ST_DEL_REMOVE,
    ST_DEL_FOLD,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    TBL_NONE,
    TBL_INSERT,
    TBL_REMOVE,
    TBL_DELTA
  } tbl_op_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
    logic [PER_W-1:0]   period;
  } entry_t;

  typedef struct packed {
    tbl_op_e            op;
    logic [IDX_W-1:0]   pos;
    entry_t             entry;
    logic               adj_en;
    logic [DELTA_W-1:0] value;
  } tbl_cmd_t;

  typedef struct packed {
    logic [DELTA_W-1:0] a;
    logic [DELTA_W-1:0] b;
    logic               sub;
  } alu_req_t;

  typedef struct packed {
    logic [DELTA_W-1:0] res;
    logic               neg;
  } alu_rsp_t;

endpackage

// ===== src/dlts_if.sv =====
// ----------------------------------------------------------------------------
// dlts_if
// Request, response and configuration channels of the task scheduler.
// ----------------------------------------------------------------------------
interface dlts_req_if;
  logic                         valid;
  logic                         ready;
  logic [dlts_pkg::OP_W-1:0]    operation;
  logic [dlts_pkg::ID_W-1:0]    task_id;
  logic [dlts_pkg::DELAY_W-1:0] start_delay;
  logic [dlts_pkg::PER_W-1:0]   repeat_period;

  modport source (output valid, operation, task_id, start_delay, repeat_period,
                  input ready);
  modport sink   (input valid, operation, task_id, start_delay, repeat_period,
                  output ready);
endinterface

interface dlts_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      op_success;
  logic                      dispatch_valid;
  logic [dlts_pkg::ID_W-1:0] dispatched_id;
  logic [dlts_pkg::TC_W-1:0] task_count;

  modport source (output valid, op_success, dispatch_valid, dispatched_id, task_count,
                  input ready);
  modport sink   (input valid, op_success, dispatch_valid, dispatched_id, task_count,
                  output ready);
endinterface

interface dlts_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dlts_pkg::SCALE_W-1:0] period_scale;

  modport source (output valid, period_scale, input ready);
  modport sink   (input valid, period_scale, output ready);
endinterface

// ===== src/delta_list_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// Timer task queue held as an ordered delta list.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is high only while the sequencer is
// idle. A request walks the entry table through its single read port, one
// entry per cycle, with one saturating adder shared by every add and subtract.
// Add walks to its slot, then shifts the entry in; check and delete search by
// id, and a delete hit removes the entry, then folds its delta into the next;
// a dispatch that pops a due periodic task re-queues it through the add walk.
// Undefined codes and adds to a full table go straight to the response state,
// which loads the response; it is valid from the following cycle. A finished
// response waits in its register without blocking the next request.
module delta_list_task_scheduler (
  input logic        clk_i,
  input logic        rst_ni,
  dlts_req_if.sink   req_i,
  dlts_cfg_if.sink   cfg_i,
  dlts_rsp_if.source rsp_o
);

  dlts_pkg::tbl_cmd_t         tbl_cmd;
  logic [dlts_pkg::IDX_W-1:0] rd_idx;
  dlts_pkg::entry_t           rd_ent;
  dlts_pkg::alu_req_t         alu_req;
  dlts_pkg::alu_rsp_t         alu_rsp;

  dlts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .rsp       (rsp_o),
    .cfg       (cfg_i),
    .tbl_cmd_o (tbl_cmd),
    .rd_idx_o  (rd_idx),
    .rd_i      (rd_ent),
    .alu_req_o (alu_req),
    .alu_rsp_i (alu_rsp)
  );

  dlts_table u_table (
    .clk_i    (clk_i),
    .cmd_i    (tbl_cmd),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_ent)
  );

  dlts_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

endmodule

// ===== src/dlts_alu.sv =====
// ----------------------------------------------------------------------------
// dlts_alu
// Shared saturating 32-bit add/subtract with exact sign of the result.
// ----------------------------------------------------------------------------
module dlts_alu (
  input  dlts_pkg::alu_req_t req_i,
  output dlts_pkg::alu_rsp_t rsp_o
);

  logic [dlts_pkg::DELTA_W:0] a_x;
  logic [dlts_pkg::DELTA_W:0] b_x;
  logic [dlts_pkg::DELTA_W:0] sum;

  assign a_x = {req_i.a[dlts_pkg::DELTA_W-1], req_i.a};
  assign b_x = {req_i.b[dlts_pkg::DELTA_W-1], req_i.b};
  assign sum = req_i.sub ? (a_x - b_x) : (a_x + b_x);

  always_comb begin
    rsp_o.neg = sum[dlts_pkg::DELTA_W];
    if (sum[dlts_pkg::DELTA_W] != sum[dlts_pkg::DELTA_W-1]) begin
      // overflow: clamp towards the true sign
      rsp_o.res = sum[dlts_pkg::DELTA_W] ? {1'b1, {(dlts_pkg::DELTA_W-1){1'b0}}}
                                         : {1'b0, {(dlts_pkg::DELTA_W-1){1'b1}}};
    end else begin
      rsp_o.res = sum[dlts_pkg::DELTA_W-1:0];
    end
  end

endmodule

// ===== src/dlts_table.sv =====
// ----------------------------------------------------------------------------
// dlts_table
// Ordered entry table: one read port, insert/remove shifts and delta writes.
// ----------------------------------------------------------------------------
module dlts_table (
  input  logic                       clk_i,
  input  dlts_pkg::tbl_cmd_t         cmd_i,
  input  logic [dlts_pkg::IDX_W-1:0] rd_idx_i,
  output dlts_pkg::entry_t           rd_o
);

  dlts_pkg::entry_t         ent [dlts_pkg::MAX_TASKS];
  logic [dlts_pkg::IDX_W:0] pos_x;
  logic [dlts_pkg::IDX_W:0] pos_p1;

  assign pos_x  = {1'b0, cmd_i.pos};
  assign pos_p1 = pos_x + (dlts_pkg::IDX_W+1)'(1);

  for (genvar g = 0; g < dlts_pkg::MAX_TASKS; g++) begin : g_slot
    localparam logic [dlts_pkg::IDX_W:0] SLOT = (dlts_pkg::IDX_W+1)'(g);

    dlts_pkg::entry_t prev_e;
    dlts_pkg::entry_t next_e;
    dlts_pkg::entry_t slot_d;
    dlts_pkg::entry_t slot_q;

    if (g == 0) begin : g_first
      assign prev_e = slot_q;
    end else begin : g_prev
      assign prev_e = ent[g-1];
    end

    if (g == dlts_pkg::MAX_TASKS - 1) begin : g_last
      assign next_e = slot_q;
    end else begin : g_next
      assign next_e = ent[g+1];
    end

    always_comb begin
      slot_d = slot_q;
      unique case (cmd_i.op)
        dlts_pkg::TBL_INSERT: begin
          if (SLOT == pos_x) begin
            slot_d = cmd_i.entry;
          end else if (SLOT > pos_x) begin
            slot_d = prev_e;
            if (SLOT == pos_p1 && cmd_i.adj_en) begin
              slot_d.delta = cmd_i.value;
            end
          end
        end
        dlts_pkg::TBL_REMOVE: begin
          if (SLOT >= pos_x) begin
            slot_d = next_e;
          end
        end
        dlts_pkg::TBL_DELTA: begin
          if (SLOT == pos_x) begin
            slot_d.delta = cmd_i.value;
          end
        end
        default: begin
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      slot_q <= slot_d;
    end

    assign ent[g] = slot_q;
  end

  assign rd_o = ent[rd_idx_i];

endmodule

// ===== src/dlts_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlts_ctrl
// Sequencer: walks the table, drives the shared ALU, holds count and result.
// ----------------------------------------------------------------------------
module dlts_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dlts_req_if.sink                   req,
  dlts_rsp_if.source                 rsp,
  dlts_cfg_if.sink                   cfg,
  output dlts_pkg::tbl_cmd_t         tbl_cmd_o,
  output logic [dlts_pkg::IDX_W-1:0] rd_idx_o,
  input  dlts_pkg::entry_t           rd_i,
  output dlts_pkg::alu_req_t         alu_req_o,
  input  dlts_pkg::alu_rsp_t         alu_rsp_i
);

  dlts_pkg::state_e state_q, state_d;

  logic [dlts_pkg::CNT_W-1:0]   count_q, count_d;
  logic [dlts_pkg::CNT_W-1:0]   ptr_q, ptr_d;
  logic [dlts_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic [dlts_pkg::OP_W-1:0]    op_q, op_d;
  logic [dlts_pkg::ID_W-1:0]    id_q, id_d;
  logic [dlts_pkg::DELTA_W-1:0] dly_q, dly_d;
  logic [dlts_pkg::PER_W-1:0]   per_q, per_d;
  logic                         succ_q, succ_d;
  logic                         dv_q, dv_d;
  logic [dlts_pkg::ID_W-1:0]    pid_q, pid_d;

  logic                         rv_q, rv_d;
  logic                         ro_succ_q, ro_succ_d;
  logic                         ro_dv_q, ro_dv_d;
  logic [dlts_pkg::ID_W-1:0]    ro_pid_q, ro_pid_d;
  logic [dlts_pkg::TC_W-1:0]    ro_tc_q, ro_tc_d;

  logic                                 in_range;
  logic                                 full;
  logic                                 empty;
  logic                                 head_due;
  logic                                 out_free;
  logic [dlts_pkg::PER_W+dlts_pkg::SCALE_W-1:0] requeue;

  assign in_range = ptr_q < count_q;
  assign full     = count_q >= dlts_pkg::CNT_W'(dlts_pkg::MAX_TASKS);
  assign empty    = count_q == '0;
  assign head_due = rd_i.delta[dlts_pkg::DELTA_W-1] || (rd_i.delta == '0);
  assign out_free = !rv_q || rsp.ready;
  assign requeue  = rd_i.period * scale_q;
  assign rd_idx_o = ptr_q[dlts_pkg::IDX_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlts_pkg::ST_IDLE: begin
        if (req.valid) begin
          unique case (req.operation)
            dlts_pkg::OP_ADD:      state_d = full ? dlts_pkg::ST_RESP : dlts_pkg::ST_INS_WALK;
            dlts_pkg::OP_TICK:     state_d = dlts_pkg::ST_TICK;
            dlts_pkg::OP_DISPATCH: state_d = dlts_pkg::ST_DISP;
            dlts_pkg::OP_CHECK,
            dlts_pkg::OP_DELETE:   state_d = dlts_pkg::ST_SRCH;
            default:               state_d = dlts_pkg::ST_RESP;
          endcase
        end
      end
      dlts_pkg::ST_INS_WALK: begin
        if (!(in_range && !alu_rsp_i.neg)) state_d = dlts_pkg::ST_INS_SHIFT;
      end
      dlts_pkg::ST_INS_SHIFT: state_d = dlts_pkg::ST_RESP;
      dlts_pkg::ST_TICK:      state_d = dlts_pkg::ST_RESP;
      dlts_pkg::ST_DISP: begin
        if (!empty && head_due && rd_i.period != '0) state_d = dlts_pkg::ST_INS_WALK;
        else                                         state_d = dlts_pkg::ST_RESP;
      end
      dlts_pkg::ST_SRCH: begin
        if (!in_range) begin
          state_d = dlts_pkg::ST_RESP;
        end else if (rd_i.id == id_q) begin
          state_d = (op_q == dlts_pkg::OP_DELETE) ? dlts_pkg::ST_DEL_REMOVE
                                                  : dlts_pkg::ST_RESP;
        end
      end
      dlts_pkg::ST_DEL_REMOVE: state_d = dlts_pkg::ST_DEL_FOLD;
      dlts_pkg::ST_DEL_FOLD:   state_d = dlts_pkg::ST_RESP;
      dlts_pkg::ST_RESP: begin
        if (out_free) state_d = dlts_pkg::ST_IDLE;
      end
      default: state_d = dlts_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_d   = count_q;
    ptr_d     = ptr_q;
    op_d      = op_q;
    id_d      = id_q;
    dly_d     = dly_q;
    per_d     = per_q;
    succ_d    = succ_q;
    dv_d      = dv_q;
    pid_d     = pid_q;
    rv_d      = rv_q && !rsp.ready;
    ro_succ_d = ro_succ_q;
    ro_dv_d   = ro_dv_q;
    ro_pid_d  = ro_pid_q;
    ro_tc_d   = ro_tc_q;
    scale_d   = cfg.valid ? cfg.period_scale : scale_q;

    req.ready = (state_q == dlts_pkg::ST_IDLE);
    cfg.ready = 1'b1;

    tbl_cmd_o        = '0;
    tbl_cmd_o.op     = dlts_pkg::TBL_NONE;
    tbl_cmd_o.pos    = ptr_q[dlts_pkg::IDX_W-1:0];
    tbl_cmd_o.entry  = '{id: id_q, delta: dly_q, period: per_q};

    alu_req_o.a   = dly_q;
    alu_req_o.b   = rd_i.delta;
    alu_req_o.sub = 1'b1;

    unique case (state_q)
      dlts_pkg::ST_IDLE: begin
        if (req.valid) begin
          op_d   = req.operation;
          id_d   = req.task_id;
          dly_d  = dlts_pkg::DELTA_W'(req.start_delay);
          per_d  = req.repeat_period;
          ptr_d  = '0;
          succ_d = (req.operation == dlts_pkg::OP_ADD) && !full;
          dv_d   = 1'b0;
          pid_d  = '0;
        end
      end
      dlts_pkg::ST_INS_WALK: begin
        if (in_range && !alu_rsp_i.neg) begin
          dly_d = alu_rsp_i.res;
          ptr_d = ptr_q + dlts_pkg::CNT_W'(1);
        end
      end
      dlts_pkg::ST_INS_SHIFT: begin
        alu_req_o.a      = rd_i.delta;
        alu_req_o.b      = dly_q;
        tbl_cmd_o.op     = dlts_pkg::TBL_INSERT;
        tbl_cmd_o.adj_en = in_range;
        tbl_cmd_o.value  = alu_rsp_i.res;
        count_d          = count_q + dlts_pkg::CNT_W'(1);
      end
      dlts_pkg::ST_TICK: begin
        alu_req_o.a     = rd_i.delta;
        alu_req_o.b     = dlts_pkg::DELTA_W'(1);
        tbl_cmd_o.value = alu_rsp_i.res;
        if (!empty) tbl_cmd_o.op = dlts_pkg::TBL_DELTA;
      end
      dlts_pkg::ST_DISP: begin
        if (!empty && head_due) begin
          tbl_cmd_o.op = dlts_pkg::TBL_REMOVE;
          count_d      = count_q - dlts_pkg::CNT_W'(1);
          dv_d         = 1'b1;
          pid_d        = rd_i.id;
          id_d         = rd_i.id;
          per_d        = rd_i.period;
          dly_d        = dlts_pkg::DELTA_W'(requeue);
          ptr_d        = '0;
        end
      end
      dlts_pkg::ST_SRCH: begin
        if (in_range) begin
          if (rd_i.id == id_q) begin
            succ_d = 1'b1;
            dly_d  = rd_i.delta;
          end else begin
            ptr_d = ptr_q + dlts_pkg::CNT_W'(1);
          end
        end
      end
      dlts_pkg::ST_DEL_REMOVE: begin
        tbl_cmd_o.op = dlts_pkg::TBL_REMOVE;
        count_d      = count_q - dlts_pkg::CNT_W'(1);
      end
      dlts_pkg::ST_DEL_FOLD: begin
        // fold the removed delay into the new occupant of the slot
        alu_req_o.a     = rd_i.delta;
        alu_req_o.b     = dly_q;
        alu_req_o.sub   = 1'b0;
        tbl_cmd_o.value = alu_rsp_i.res;
        if (in_range) tbl_cmd_o.op = dlts_pkg::TBL_DELTA;
      end
      dlts_pkg::ST_RESP: begin
        if (out_free) begin
          rv_d      = 1'b1;
          ro_succ_d = succ_q;
          ro_dv_d   = dv_q;
          ro_pid_d  = pid_q;
          ro_tc_d   = dlts_pkg::TC_W'(count_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlts_pkg::ST_IDLE;
      count_q <= '0;
      scale_q <= dlts_pkg::SCALE_RESET;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scale_q <= scale_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    op_q      <= op_d;
    id_q      <= id_d;
    dly_q     <= dly_d;
    per_q     <= per_d;
    succ_q    <= succ_d;
    dv_q      <= dv_d;
    pid_q     <= pid_d;
    ro_succ_q <= ro_succ_d;
    ro_dv_q   <= ro_dv_d;
    ro_pid_q  <= ro_pid_d;
    ro_tc_q   <= ro_tc_d;
  end

  assign rsp.valid          = rv_q;
  assign rsp.op_success     = ro_succ_q;
  assign rsp.dispatch_valid = ro_dv_q;
  assign rsp.dispatched_id  = ro_pid_q;
  assign rsp.task_count     = ro_tc_q;

endmodule

// ===== src/dlts_checker.sv =====
// ----------------------------------------------------------------------------
// dlts_checker
// Port-level checks of the task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module dlts_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      op_success_i,
  input logic                      dispatch_valid_i,
  input logic [dlts_pkg::ID_W-1:0] dispatched_id_i,
  input logic [dlts_pkg::TC_W-1:0] task_count_i
);

  // one request in flight: never ready straight after a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready high in cycle after accepted request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(op_success_i) &&
      $stable(dispatch_valid_i) && $stable(dispatched_id_i) && $stable(task_count_i))
    else $error("stalled response changed");

  a_disp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && dispatch_valid_i |-> !op_success_i)
    else $error("dispatch response flags success");

  a_disp_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !dispatch_valid_i |-> dispatched_id_i == '0)
    else $error("id reported without dispatch");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> int'(task_count_i) <= dlts_pkg::MAX_TASKS)
    else $error("task count above table size");

endmodule

bind delta_list_task_scheduler dlts_checker u_dlts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .op_success_i     (rsp_o.op_success),
  .dispatch_valid_i (rsp_o.dispatch_valid),
  .dispatched_id_i  (rsp_o.dispatched_id),
  .task_count_i     (rsp_o.task_count)
);

// ===== dv/delta_list_task_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_tb
// Self-checking bench for the delta-list task scheduler. It predicts every
// response from a timer table kept in the bench, checks each response field
// by field in order, and covers directed corner requests, a full table,
// random traffic under several period scales, and a long response hold-off.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_tb;

  localparam int CLK_HALF      = 6;
  localparam int RST_CYCLES    = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = dlts_pkg::MAX_TASKS + 8;
  localparam int HOLD_CYCLES   = 200;

  localparam logic [dlts_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [dlts_pkg::OP_W-1:0] OP_RSVD_MID   = 3'd6;
  localparam logic [dlts_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  localparam longint DELTA_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint DELTA_MIN   = 64'shFFFF_FFFF_8000_0000;
  localparam int     DELTA_FLOOR = -2147483647 - 1;

  typedef struct packed {
    logic                      ok;
    logic                      popped;
    logic [dlts_pkg::ID_W-1:0] pid;
    logic [dlts_pkg::TC_W-1:0] count;
  } outcome_t;

  typedef struct {
    logic [dlts_pkg::ID_W-1:0]  id;
    int                         delta;
    logic [dlts_pkg::PER_W-1:0] period;
  } slot_t;

  logic clk;
  logic rst_n;

  dlts_req_if req_if ();
  dlts_rsp_if rsp_if ();
  dlts_cfg_if cfg_if ();

  delta_list_task_scheduler u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  slot_t                        timers [dlts_pkg::MAX_TASKS];
  int unsigned                  timer_cnt = 0;
  logic [dlts_pkg::SCALE_W-1:0] scale_q   = dlts_pkg::SCALE_RESET;
  outcome_t                     pending_outcomes [$];

  int          errors      = 0;
  int          accepted    = 0;
  int          pops        = 0;
  int          rejects     = 0;
  int          scales_used = 0;
  int          hold_req    = 0;
  bit          idle_en     = 1'b1;
  int unsigned cycle_cnt   = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("%0t timeout after %0d cycles, %0d responses outstanding", $time, cycle_cnt,
             pending_outcomes.size());
    $display("status: fail");
    $finish;
  end

  // ---- timer table prediction ----

  function automatic int sat_delta(longint v);
    if (v > DELTA_MAX) return int'(DELTA_MAX);
    if (v < DELTA_MIN) return int'(DELTA_MIN);
    return int'(v);
  endfunction

  function automatic bit timer_insert(logic [dlts_pkg::ID_W-1:0] id, longint delay,
                                      logic [dlts_pkg::PER_W-1:0] per);
    int unsigned pos = 0;
    int          d;
    if (timer_cnt >= dlts_pkg::MAX_TASKS) return 1'b0;
    d = sat_delta(delay);
    while (pos < timer_cnt && d >= timers[pos].delta) begin
      d = sat_delta(longint'(d) - longint'(timers[pos].delta));
      pos++;
    end
    if (pos < timer_cnt) timers[pos].delta = sat_delta(longint'(timers[pos].delta) - longint'(d));
    for (int unsigned k = timer_cnt; k > pos; k--) timers[k] = timers[k-1];
    timers[pos] = '{id: id, delta: d, period: per};
    timer_cnt++;
    return 1'b1;
  endfunction

  function automatic void timer_remove(int unsigned pos);
    for (int unsigned k = pos; k + 1 < timer_cnt; k++) timers[k] = timers[k+1];
    timer_cnt--;
  endfunction

  function automatic outcome_t schedule_step(logic [dlts_pkg::OP_W-1:0] op,
                                             logic [dlts_pkg::ID_W-1:0] id,
                                             logic [dlts_pkg::DELAY_W-1:0] dly,
                                             logic [dlts_pkg::PER_W-1:0] per);
    outcome_t                   res;
    logic [dlts_pkg::ID_W-1:0]  pid;
    logic [dlts_pkg::PER_W-1:0] pper;
    res = '0;
    case (op)
      dlts_pkg::OP_ADD: begin
        res.ok = timer_insert(id, longint'(dly), per);
      end
      dlts_pkg::OP_TICK: begin
        if (timer_cnt > 0 && timers[0].delta > DELTA_FLOOR) timers[0].delta--;
      end
      dlts_pkg::OP_DISPATCH: begin
        if (timer_cnt > 0 && timers[0].delta <= 0) begin
          pid  = timers[0].id;
          pper = timers[0].period;
          timer_remove(0);
          res.popped = 1'b1;
          res.pid    = pid;
          // popped delay is dropped; periodic tasks go back in at period * scale
          if (pper != '0) void'(timer_insert(pid, longint'(pper) * longint'(scale_q), pper));
        end
      end
      dlts_pkg::OP_CHECK: begin
        for (int unsigned k = 0; k < timer_cnt; k++) begin
          if (timers[k].id == id) begin
            res.ok = 1'b1;
            break;
          end
        end
      end
      dlts_pkg::OP_DELETE: begin
        for (int unsigned k = 0; k < timer_cnt; k++) begin
          if (timers[k].id == id) begin
            if (k + 1 < timer_cnt) begin
              timers[k+1].delta = sat_delta(longint'(timers[k+1].delta) +
                                            longint'(timers[k].delta));
            end
            timer_remove(k);
            res.ok = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    res.count = dlts_pkg::TC_W'(timer_cnt);
    return res;
  endfunction

  // ---- request side ----

  // entered just after a rising edge; leaves valid high for a following request
  task automatic send_request(logic [dlts_pkg::OP_W-1:0] op, logic [dlts_pkg::ID_W-1:0] id,
                              logic [dlts_pkg::DELAY_W-1:0] dly,
                              logic [dlts_pkg::PER_W-1:0] per);
    outcome_t exp_o;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= op;
    req_if.task_id       <= id;
    req_if.start_delay   <= dly;
    req_if.repeat_period <= per;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    exp_o = schedule_step(op, id, dly, per);
    pending_outcomes.push_back(exp_o);
    accepted++;
    if (exp_o.popped) pops++;
    if (op == dlts_pkg::OP_ADD && !exp_o.ok) rejects++;
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(logic [dlts_pkg::SCALE_W-1:0] value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.period_scale <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    scale_q = value;
    scales_used++;
  endtask

  // ---- response side ----

  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_req > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = hold_req - 1;
        hold_req   = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t response with no request outstanding: expected none, actual %0h/%0h/%0h/%0h",
                 $time, rsp_if.op_success, rsp_if.dispatch_valid, rsp_if.dispatched_id,
                 rsp_if.task_count);
      end else begin
        exp_o = pending_outcomes.pop_front();
        compare_field("op_success", 32'(exp_o.ok), 32'(rsp_if.op_success));
        compare_field("dispatch_valid", 32'(exp_o.popped), 32'(rsp_if.dispatch_valid));
        compare_field("dispatched_id", 32'(exp_o.pid), 32'(rsp_if.dispatched_id));
        compare_field("task_count", 32'(exp_o.count), 32'(rsp_if.task_count));
      end
    end
  end

  // ---- tests ----

  task automatic test_directed();
    send_request(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);  // empty queue
    send_request(dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000);
    send_request(dlts_pkg::OP_CHECK,    8'h00, 16'h0000, 16'h0000);
    send_request(dlts_pkg::OP_DELETE,   8'h00, 16'h0000, 16'h0000);
    send_request(dlts_pkg::OP_ADD,      8'h00, 16'h0000, 16'h0000);
    send_request(dlts_pkg::OP_DELETE,   8'hFF, 16'h0000, 16'h0000);  // lone entry, other id
    send_request(dlts_pkg::OP_CHECK,    8'h00, 16'hFFFF, 16'hFFFF);
    send_request(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);  // one-shot, no re-queue
    send_request(dlts_pkg::OP_ADD,      8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(dlts_pkg::OP_ADD,      8'hAA, 16'h0002, 16'h0001);
    send_request(dlts_pkg::OP_ADD,      8'h55, 16'h0002, 16'h0000);  // equal delay goes after
    send_request(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);  // head not yet due
    send_request(dlts_pkg::OP_TICK,     8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000);
    send_request(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);  // periodic re-queue
    send_request(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    send_request(dlts_pkg::OP_TICK,     8'h00, 16'h0000, 16'h0000);  // head counts down, not yet due
    send_request(dlts_pkg::OP_ADD,      8'h33, 16'h0005, 16'h0003);
    send_request(dlts_pkg::OP_DELETE,   8'hAA, 16'h0000, 16'h0000);  // delta folds into successor
    send_request(dlts_pkg::OP_CHECK,    8'hFF, 16'h0000, 16'h0000);
    send_request(OP_RSVD_FIRST, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_RSVD_LAST,  8'h33, 16'h1234, 16'h0001);
    send_request(OP_RSVD_MID,   8'h00, 16'h0000, 16'h0000);
    send_request(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);
  endtask

  task automatic test_full_table();
    while (timer_cnt < dlts_pkg::MAX_TASKS) begin
      send_request(dlts_pkg::OP_ADD, dlts_pkg::ID_W'($urandom_range(0, 255)),
                   dlts_pkg::DELAY_W'($urandom_range(0, 40)),
                   dlts_pkg::PER_W'($urandom_range(0, 3)));
    end
    // full, rejected
    send_request(dlts_pkg::OP_ADD, dlts_pkg::ID_W'($urandom_range(0, 255)), 16'h0000, 16'h0001);
    send_request(dlts_pkg::OP_ADD, dlts_pkg::ID_W'($urandom_range(0, 255)), 16'hFFFF, 16'h0000);
    send_request(dlts_pkg::OP_CHECK, timers[dlts_pkg::MAX_TASKS-1].id, 16'h0000, 16'h0000);
    while (timer_cnt > 0) begin
      send_request(dlts_pkg::OP_DELETE, timers[$urandom_range(0, timer_cnt - 1)].id,
                   16'h0000, 16'h0000);
    end
  endtask

  task automatic test_random(int n);
    int                           r;
    logic [dlts_pkg::OP_W-1:0]    op;
    logic [dlts_pkg::ID_W-1:0]    id;
    logic [dlts_pkg::DELAY_W-1:0] dly;
    logic [dlts_pkg::PER_W-1:0]   per;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22)      op = dlts_pkg::OP_ADD;
      else if (r < 52) op = dlts_pkg::OP_TICK;
      else if (r < 70) op = dlts_pkg::OP_DISPATCH;
      else if (r < 80) op = dlts_pkg::OP_CHECK;
      else if (r < 93) op = dlts_pkg::OP_DELETE;
      else             op = dlts_pkg::OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));

      if (timer_cnt > 0 && $urandom_range(0, 1) == 1)
        id = timers[$urandom_range(0, timer_cnt - 1)].id;
      else if ($urandom_range(0, 4) != 0)
        id = dlts_pkg::ID_W'($urandom_range(0, 23));
      else
        id = dlts_pkg::ID_W'($urandom_range(0, 255));

      r = $urandom_range(0, 9);
      if (r < 7)      dly = dlts_pkg::DELAY_W'($urandom_range(0, 12));
      else if (r < 9) dly = dlts_pkg::DELAY_W'($urandom_range(0, 300));
      else            dly = dlts_pkg::DELAY_W'($urandom_range(0, 65535));

      r = $urandom_range(0, 9);
      if (r < 4)      per = '0;
      else if (r < 8) per = dlts_pkg::PER_W'($urandom_range(1, 4));
      else if (r < 9) per = dlts_pkg::PER_W'($urandom_range(5, 60));
      else            per = dlts_pkg::PER_W'($urandom_range(0, 65535));

      send_request(op, id, dly, per);
    end
  endtask

  // responses held off while requests keep coming, then a full pause
  task automatic test_backpressure();
    wait_drain();
    hold_req = HOLD_CYCLES;
    test_random(12);
    wait_drain();
  endtask

  initial begin
    rst_n                <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.operation     <= dlts_pkg::OP_ADD;
    req_if.task_id       <= '0;
    req_if.start_delay   <= '0;
    req_if.repeat_period <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.period_scale  <= dlts_pkg::SCALE_RESET;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    write_scale(8'd1);
    test_random(500);
    test_backpressure();
    write_scale(8'd255);
    test_random(450);
    write_scale(dlts_pkg::SCALE_W'($urandom_range(2, 254)));
    test_random(450);
    write_scale(dlts_pkg::SCALE_RESET);
    idle_en = 1'b0;
    test_random(350);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d requests: %0d tasks dispatched, %0d adds turned away",
             accepted, pops, rejects);
    $display("period scale rewritten %0d times, extremes included; %0d mismatches",
             scales_used, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dlts_pkg.sv
src/dlts_if.sv
src/dlts_alu.sv
src/dlts_table.sv
src/dlts_ctrl.sv
src/delta_list_task_scheduler.sv
src/dlts_checker.sv
dv/delta_list_task_scheduler_tb.sv
